@@ hdl/polr_pkg.sv @@
package polr_pkg;

	// Default coordinate width and the colour register layout.
	localparam int COORD_BITS_DEF = 5;
	localparam int COLOR_W = 4;
	localparam logic [COLOR_W-1:0] PEN_COLOR_RESET = 4'hF;

	// Pixels delivered for one vertex at most, and the width of their counter.
	localparam int MAX_RESULTS = 64;
	localparam int CNT_W = $clog2(MAX_RESULTS);

	// Sequencer states of the outline walker.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_MUL,
		ST_DIVS,
		ST_DIVW,
		ST_EMIT
	} state_t;

endpackage

@@ hdl/polygon_outline_rasterizer_unit.sv @@
// A vertex that opens a polygon yields no pixel. Each pixel of a sloped edge takes
// one bit-serial divider pass; a vertical edge emits its pixels directly. Each edge
// passes through a setup state, and through a bit-serial multiply when it runs
// toward smaller x. The block takes one vertex at a time: a new vertex is accepted
// only while idle. Reset clears the polygon state and sets the pen colour to 15.
module polygon_outline_rasterizer_unit import polr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [COLOR_W-1:0]    cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COORD_BITS-1:0] vertex_x,
	input  logic [COORD_BITS-1:0] vertex_y,
	input  logic                  last_vertex,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic [COLOR_W-1:0]    pixel_color,
	output logic                  run_end
);

	localparam int PW = 2 * COORD_BITS;

	state_t state_q, state_d;

	logic [COLOR_W-1:0] pen_color_q;
	logic open_q;
	logic [COORD_BITS-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic [COORD_BITS-1:0] xs_q, ys_q, xe_q, ye_q;
	logic second_q;
	logic [COORD_BITS-1:0] it_q;
	logic [PW-1:0] prod_q;
	logic [CNT_W-1:0] count_q;

	logic out_valid_q;
	logic [COORD_BITS-1:0] pixel_x_q, pixel_y_q;
	logic [COLOR_W-1:0] pixel_color_q;
	logic run_end_q;

	logic in_accept, out_free;
	logic x_desc, y_desc, vert, zero;
	logic [COORD_BITS-1:0] adx, ady, lo, hi;
	logic edge_last, cap, step_end;
	logic [COORD_BITS-1:0] y_nv, px, py;
	logic mul_start, mul_busy, div_start, div_busy, div_rem_nz, emit;
	logic [PW-1:0] mul_prod;
	logic [COORD_BITS-1:0] div_quot;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_accept = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// Edge geometry from the current endpoints.
	assign x_desc = (xs_q > xe_q);
	assign y_desc = (ys_q > ye_q);
	assign vert   = (xs_q == xe_q);
	assign zero   = vert && (ys_q == ye_q);
	assign adx    = x_desc ? (xs_q - xe_q) : (xe_q - xs_q);
	assign ady    = y_desc ? (ys_q - ye_q) : (ye_q - ys_q);
	assign lo     = vert ? (y_desc ? ye_q : ys_q) : (x_desc ? xe_q : xs_q);
	assign hi     = vert ? (y_desc ? ys_q : ye_q) : (x_desc ? xs_q : xe_q);

	// The final pixel of an edge, of the whole vertex, and the pixel cap.
	assign edge_last = zero || (it_q == hi - 1'b1);
	assign cap       = (count_q == CNT_W'(MAX_RESULTS - 1));
	assign step_end  = cap || (edge_last && !second_q);

	// Along x the offset and dx share a sign, so the floor only needs
	// correcting when the edge falls in y.
	assign y_nv = y_desc ? (ys_q - div_quot - COORD_BITS'(div_rem_nz)) : (ys_q + div_quot);
	assign px   = vert ? xs_q : it_q;
	assign py   = zero ? ys_q : (vert ? it_q : y_nv);

	polr_mul #(
		.COORD_BITS(COORD_BITS)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mcand  (ady),
		.mplier (adx),
		.busy   (mul_busy),
		.prod   (mul_prod)
	);

	polr_div #(
		.COORD_BITS(COORD_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (adx),
		.busy     (div_busy),
		.quot     (div_quot),
		.rem_nz   (div_rem_nz)
	);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and unit strobes.
	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		div_start = 1'b0;
		emit      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_accept && (open_q || last_vertex)) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				if (vert) begin
					state_d = ST_EMIT;
				end else if (x_desc) begin
					mul_start = 1'b1;
					state_d   = ST_MUL;
				end else begin
					state_d = ST_DIVS;
				end
			end
			ST_MUL: begin
				if (!mul_busy) begin
					state_d = ST_DIVS;
				end
			end
			ST_DIVS: begin
				div_start = 1'b1;
				state_d   = ST_DIVW;
			end
			ST_DIVW, ST_EMIT: begin
				if (out_free && !(state_q == ST_DIVW && div_busy)) begin
					emit = 1'b1;
					if (step_end) begin
						state_d = ST_IDLE;
					end else if (edge_last) begin
						state_d = ST_SETUP;
					end else if (vert) begin
						state_d = ST_EMIT;
					end else begin
						state_d = ST_DIVS;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers: colour, polygon status and vertices, closing-edge flag, pixel count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_color_q <= PEN_COLOR_RESET;
			open_q      <= 1'b0;
			first_x_q   <= '0;
			first_y_q   <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			second_q    <= 1'b0;
			count_q     <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				pen_color_q <= cfg_data;
			end
			if (in_accept) begin
				count_q <= '0;
				if (!open_q) begin
					second_q <= 1'b0;
					if (!last_vertex) begin
						first_x_q <= vertex_x;
						first_y_q <= vertex_y;
						prev_x_q  <= vertex_x;
						prev_y_q  <= vertex_y;
						open_q    <= 1'b1;
					end
				end else begin
					prev_x_q <= vertex_x;
					prev_y_q <= vertex_y;
					second_q <= last_vertex;
					open_q   <= !last_vertex;
				end
			end else if (emit) begin
				count_q <= count_q + 1'b1;
				if (!step_end && edge_last) begin
					second_q <= 1'b0;
				end
			end
		end
	end

	// Edge endpoints, walk position and running product |x - xs| * |dy|.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			if (!open_q) begin
				xs_q <= vertex_x;
				ys_q <= vertex_y;
			end else begin
				xs_q <= prev_x_q;
				ys_q <= prev_y_q;
			end
			xe_q <= vertex_x;
			ye_q <= vertex_y;
		end else if (state_q == ST_SETUP) begin
			it_q   <= lo;
			prod_q <= '0;
		end else if (state_q == ST_MUL && !mul_busy) begin
			prod_q <= mul_prod;
		end else if (emit && !step_end) begin
			if (edge_last) begin
				// Closing edge runs from the current vertex back to the first.
				xs_q <= prev_x_q;
				ys_q <= prev_y_q;
				xe_q <= first_x_q;
				ye_q <= first_y_q;
			end else begin
				it_q   <= it_q + 1'b1;
				prod_q <= x_desc ? (prod_q - PW'(ady)) : (prod_q + PW'(ady));
			end
		end
	end

	// Output register: holds one pixel until its transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pixel_x_q     <= px;
			pixel_y_q     <= py;
			pixel_color_q <= pen_color_q;
			run_end_q     <= step_end;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = pixel_x_q;
	assign pixel_y     = pixel_y_q;
	assign pixel_color = pixel_color_q;
	assign run_end     = run_end_q;

endmodule

@@ hdl/polr_mul.sv @@
module polr_mul import polr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [COORD_BITS-1:0]   mcand,
	input  logic [COORD_BITS-1:0]   mplier,
	output logic                    busy,
	output logic [2*COORD_BITS-1:0] prod
);

	localparam int PW = 2 * COORD_BITS;
	localparam int CW = $clog2(COORD_BITS + 1);

	logic [CW-1:0] cnt_q;
	logic [PW-1:0] prod_q;
	logic [PW-1:0] mcand_q;
	logic [COORD_BITS-1:0] mplier_q;

	// Step counter: one multiplier bit is consumed per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(COORD_BITS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Shift-and-add datapath: the multiplier shifts out low bit first.
	always_ff @(posedge clk) begin
		if (start) begin
			prod_q   <= '0;
			mcand_q  <= PW'(mcand);
			mplier_q <= mplier;
		end else if (cnt_q != '0) begin
			if (mplier_q[0]) begin
				prod_q <= prod_q + mcand_q;
			end
			mcand_q  <= {mcand_q[PW-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[COORD_BITS-1:1]};
		end
	end

	assign busy = (cnt_q != '0);
	assign prod = prod_q;

endmodule

@@ hdl/polr_div.sv @@
module polr_div import polr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [2*COORD_BITS-1:0] dividend,
	input  logic [COORD_BITS-1:0]   divisor,
	output logic                    busy,
	output logic [COORD_BITS-1:0]   quot,
	output logic                    rem_nz
);

	localparam int CW = $clog2(COORD_BITS + 1);

	logic [CW-1:0] cnt_q;
	logic [COORD_BITS-1:0] rem_q;
	logic [COORD_BITS-1:0] sh_q;
	logic [COORD_BITS-1:0] divisor_q;
	logic [COORD_BITS:0] trial;
	logic [COORD_BITS:0] diff;
	logic ge;

	// The quotient is known to fit in COORD_BITS, so the upper half of the
	// dividend starts as the partial remainder and one bit is resolved a cycle.
	assign trial = {rem_q, sh_q[COORD_BITS-1]};
	assign diff  = trial - {1'b0, divisor_q};
	assign ge    = (trial >= {1'b0, divisor_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(COORD_BITS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Restoring division; low dividend bits shift out as quotient bits shift in.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= dividend[2*COORD_BITS-1:COORD_BITS];
			sh_q      <= dividend[COORD_BITS-1:0];
			divisor_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
			sh_q  <= {sh_q[COORD_BITS-2:0], ge};
		end
	end

	assign busy   = (cnt_q != '0);
	assign quot   = sh_q;
	assign rem_nz = (rem_q != '0);

endmodule

@@ hdl/polr_checker.sv @@
module polr_props import polr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  last_vertex,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [COORD_BITS-1:0] pixel_x,
	input logic [COORD_BITS-1:0] pixel_y,
	input logic [COLOR_W-1:0]    pixel_color,
	input logic                  run_end
);

	// A stalled result transaction keeps its valid.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped before the transaction completed");

	// A stalled result transaction keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(pixel_x) && $stable(pixel_y)
			&& $stable(pixel_color) && $stable(run_end))
		else $error("pixel payload changed while stalled");

	// A closing vertex always draws something, so the input side goes busy.
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_vertex |=> !in_ready)
		else $error("closing vertex accepted without starting a run");

	// A fresh pixel only comes out of a run in progress.
	a_pixel_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("pixel appeared while the block was idle");

endmodule

bind polygon_outline_rasterizer_unit polr_props #(
	.COORD_BITS(COORD_BITS)
) u_polr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.last_vertex (last_vertex),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.pixel_x     (pixel_x),
	.pixel_y     (pixel_y),
	.pixel_color (pixel_color),
	.run_end     (run_end)
);

@@ verif/polr_checker.sv @@
module polr_checker import polr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [COLOR_W-1:0]    cfg_data,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [COORD_BITS-1:0] vertex_x,
	input  logic [COORD_BITS-1:0] vertex_y,
	input  logic                  last_vertex,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [COORD_BITS-1:0] pixel_x,
	input  logic [COORD_BITS-1:0] pixel_y,
	input  logic [COLOR_W-1:0]    pixel_color,
	input  logic                  run_end,
	output int                    mismatch_count,
	output int                    awaited_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COLOR_W-1:0]    color;
		logic                  run_end;
	} pixel_t;

	// Pixels still owed by the block, oldest first, and the pixels of one vertex.
	pixel_t awaited_pixels[$];
	pixel_t vertex_pixels[$];

	// Shadow copy of the pen colour and of the open polygon.
	logic [COLOR_W-1:0]    pen_color_q;
	logic [COORD_BITS-1:0] first_x_q;
	logic [COORD_BITS-1:0] first_y_q;
	logic [COORD_BITS-1:0] prev_x_q;
	logic [COORD_BITS-1:0] prev_y_q;
	logic                  polygon_open_q;

	task automatic report_mismatch(input string what);
		$display("%0t ns ERROR: %s", $time, what);
		mismatch_count++;
	endtask

	// Rounds toward minus infinity, unlike the native division.
	function automatic int floor_quot(input int num, input int den);
		int q;
		q = num / den;
		if ((num % den) != 0 && ((num < 0) != (den < 0)))
			q--;
		return q;
	endfunction

	// Pixels past the per-vertex maximum are dropped.
	function automatic void plot_pixel(input int x, input int y);
		pixel_t p;
		if (vertex_pixels.size() >= MAX_RESULTS)
			return;
		p.x = x[COORD_BITS-1:0];
		p.y = y[COORD_BITS-1:0];
		p.color = pen_color_q;
		p.run_end = 1'b0;
		vertex_pixels.push_back(p);
	endfunction

	// One edge, end pixel excluded; steps along x unless the edge is vertical.
	function automatic void trace_edge(input int xs, input int ys, input int xe, input int ye);
		int lo;
		int hi;
		if (xs != xe) begin
			lo = (xs < xe) ? xs : xe;
			hi = (xs < xe) ? xe : xs;
			for (int x = lo; x < hi; x++)
				plot_pixel(x, ys + floor_quot((x - xs) * (ye - ys), xe - xs));
		end else if (ys != ye) begin
			lo = (ys < ye) ? ys : ye;
			hi = (ys < ye) ? ye : ys;
			for (int y = lo; y < hi; y++)
				plot_pixel(xs, y);
		end else begin
			plot_pixel(xs, ys);
		end
	endfunction

	// Works out the pixels that one vertex causes and queues them.
	function automatic void rasterize_vertex(input logic [COORD_BITS-1:0] vx,
			input logic [COORD_BITS-1:0] vy, input logic closes);
		pixel_t tail;
		vertex_pixels.delete();
		if (!polygon_open_q) begin
			// A lone closing vertex is a single dot; otherwise it opens a polygon.
			if (closes) begin
				plot_pixel(vx, vy);
			end else begin
				first_x_q = vx;
				first_y_q = vy;
				prev_x_q = vx;
				prev_y_q = vy;
				polygon_open_q = 1'b1;
			end
		end else begin
			trace_edge(prev_x_q, prev_y_q, vx, vy);
			if (closes) begin
				trace_edge(vx, vy, first_x_q, first_y_q);
				polygon_open_q = 1'b0;
			end
			prev_x_q = vx;
			prev_y_q = vy;
		end
		if (vertex_pixels.size() > 0) begin
			tail = vertex_pixels.pop_back();
			tail.run_end = 1'b1;
			vertex_pixels.push_back(tail);
		end
		foreach (vertex_pixels[i])
			awaited_pixels.push_back(vertex_pixels[i]);
	endfunction

	// Watch every transaction at the clock edge.
	always @(posedge clk or negedge arst_n) begin : watch
		pixel_t want;
		if (!arst_n) begin
			pen_color_q = PEN_COLOR_RESET;
			first_x_q = '0;
			first_y_q = '0;
			prev_x_q = '0;
			prev_y_q = '0;
			polygon_open_q = 1'b0;
			awaited_pixels.delete();
			mismatch_count = 0;
			awaited_count <= 0;
		end else begin
			// Queue the prediction first so that ordering holds in any case.
			if (in_valid && in_ready)
				rasterize_vertex(vertex_x, vertex_y, last_vertex);

			// Each delivered pixel is compared with the oldest prediction.
			if (out_valid && out_ready) begin
				if (awaited_pixels.size() == 0) begin
					report_mismatch($sformatf("unexpected pixel (%0d,%0d) color %0d end %0b",
						pixel_x, pixel_y, pixel_color, run_end));
				end else begin
					want = awaited_pixels.pop_front();
					if (pixel_x !== want.x)
						report_mismatch($sformatf("pixel_x %0d, expected %0d",
							pixel_x, want.x));
					if (pixel_y !== want.y)
						report_mismatch($sformatf("pixel_y %0d, expected %0d at x %0d",
							pixel_y, want.y, want.x));
					if (pixel_color !== want.color)
						report_mismatch($sformatf("pixel_color %0d, expected %0d",
							pixel_color, want.color));
					if (run_end !== want.run_end)
						report_mismatch($sformatf("run_end %0b, expected %0b at (%0d,%0d)",
							run_end, want.run_end, want.x, want.y));
				end
			end

			// A new pen colour applies to vertices accepted after the write.
			if (cfg_valid && cfg_ready)
				pen_color_q = cfg_data;

			awaited_count <= awaited_pixels.size();
		end
	end

endmodule

@@ verif/tb_top.sv @@
module tb_top import polr_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB = COORD_BITS_DEF;
	localparam int COORD_MAX = (1 << CB) - 1;
	localparam int IDLE_PERCENT = 24;
	localparam int SETTLE_CYCLES = 20;
	localparam int TAIL_CYCLES = 64;
	localparam int HOLD_OFF_CYCLES = 1500;
	localparam int HOLD_OFF_AT = 1200;
	localparam int WATCHDOG_LIMIT = 10000;
	localparam int PHASE_ITEMS = 113;

	// Input side runs without gaps for this range of vertices, output side for this range of pixels.
	localparam int IN_QUIET_FROM = 200;
	localparam int IN_QUIET_TO = 290;
	localparam int OUT_QUIET_FROM = 2500;
	localparam int OUT_QUIET_TO = 3600;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [COLOR_W-1:0] cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [CB-1:0]      vertex_x = '0;
	logic [CB-1:0]      vertex_y = '0;
	logic               last_vertex = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [CB-1:0]      pixel_x;
	logic [CB-1:0]      pixel_y;
	logic [COLOR_W-1:0] pixel_color;
	logic               run_end;

	int mismatch_count;
	int awaited_count;
	int vertices_sent;
	int stim_prev_x;
	int stim_prev_y;
	int stall_cycles;

	polygon_outline_rasterizer_unit #(
		.COORD_BITS(CB)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.vertex_x   (vertex_x),
		.vertex_y   (vertex_y),
		.last_vertex(last_vertex),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.pixel_color(pixel_color),
		.run_end    (run_end)
	);

	polr_checker #(
		.COORD_BITS(CB)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.vertex_x      (vertex_x),
		.vertex_y      (vertex_y),
		.last_vertex   (last_vertex),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.pixel_color   (pixel_color),
		.run_end       (run_end),
		.mismatch_count(mismatch_count),
		.awaited_count (awaited_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Ends the run when no transaction of any kind happens for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Pixel sink: random back-pressure, one long hold-off, and a stretch with none.
	initial begin : pixel_sink
		int taken;
		bit held;
		taken = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				taken++;
			if (!held && taken >= HOLD_OFF_AT) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			out_ready <= (taken >= OUT_QUIET_FROM && taken < OUT_QUIET_TO) ||
				($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	// Offers one vertex and holds it until the transaction, then maybe leaves a gap.
	task automatic send_vertex(input int x, input int y, input bit closes);
		in_valid <= 1'b1;
		vertex_x <= x[CB-1:0];
		vertex_y <= y[CB-1:0];
		last_vertex <= closes;
		do @(posedge clk); while (!in_ready);
		vertices_sent++;
		stim_prev_x = x;
		stim_prev_y = y;
		if (vertices_sent < IN_QUIET_FROM || vertices_sent >= IN_QUIET_TO) begin
			while ($urandom_range(99) < IDLE_PERCENT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
	endtask

	// Picks the next corner so that vertical, horizontal and zero-length edges are common.
	task automatic send_corner(input bit closes);
		int x;
		int y;
		int pick;
		pick = $urandom_range(99);
		x = $urandom_range(COORD_MAX);
		y = $urandom_range(COORD_MAX);
		if (pick < 15) begin
			x = stim_prev_x;
		end else if (pick < 25) begin
			y = stim_prev_y;
		end else if (pick < 30) begin
			x = stim_prev_x;
			y = stim_prev_y;
		end else if (pick < 40) begin
			x = ($urandom_range(1) == 1) ? COORD_MAX : 0;
		end
		send_vertex(x, y, closes);
	endtask

	// Mostly whole polygons, with lone dots and stray vertices mixed in.
	task automatic random_phase(input int n_items);
		int stop_at;
		int corners;
		int pick;
		stop_at = vertices_sent + n_items;
		while (vertices_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 80) begin
				corners = $urandom_range(2, 6);
				for (int k = 1; k <= corners; k++)
					send_corner(k == corners);
			end else if (pick < 90) begin
				send_vertex($urandom_range(COORD_MAX), $urandom_range(COORD_MAX), 1'b1);
			end else begin
				send_vertex($urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
					$urandom_range(1));
			end
		end
	endtask

	// Lets every owed pixel come out, then gives the block time to finish an opening vertex.
	task automatic drain_block();
		in_valid <= 1'b0;
		do @(posedge clk); while (awaited_count != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_pen_color(input logic [COLOR_W-1:0] color);
		drain_block();
		cfg_valid <= 1'b1;
		cfg_data <= color;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Lone dots at the corners of the grid, with the pen colour from reset.
		send_vertex(0, 0, 1'b1);
		send_vertex(COORD_MAX, COORD_MAX, 1'b1);

		// Square walk: full-width horizontal, vertical up, edge toward smaller x,
		// a zero-length edge, vertical down, then a zero-length closing edge.
		send_vertex(0, 0, 1'b0);
		send_vertex(COORD_MAX, 0, 1'b0);
		send_vertex(COORD_MAX, COORD_MAX, 1'b0);
		send_vertex(0, COORD_MAX, 1'b0);
		send_vertex(0, COORD_MAX, 1'b0);
		send_vertex(0, 0, 1'b1);

		// Two-vertex polygon with a steep edge that the closing edge retraces.
		send_vertex(5, 3, 1'b0);
		send_vertex(20, 29, 1'b1);

		// Four-vertex polygon with a falling diagonal drawn toward smaller x.
		send_vertex(COORD_MAX, 0, 1'b0);
		send_vertex(0, COORD_MAX, 1'b0);
		send_vertex(COORD_MAX, COORD_MAX, 1'b0);
		send_vertex(2, 7, 1'b1);

		// Polygon that never moves, then dots with alternating bit patterns.
		send_vertex(10, 10, 1'b0);
		send_vertex(10, 10, 1'b1);
		send_vertex(21, 10, 1'b1);
		send_vertex(10, 21, 1'b1);

		// Random phases under different pen colours, both extremes included.
		write_pen_color('0);
		random_phase(PHASE_ITEMS);
		write_pen_color('1);
		random_phase(PHASE_ITEMS);
		write_pen_color(COLOR_W'($urandom_range(1, (1 << COLOR_W) - 2)));
		random_phase(PHASE_ITEMS);
		write_pen_color(COLOR_W'($urandom_range((1 << COLOR_W) - 1)));
		random_phase(PHASE_ITEMS);

		drain_block();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && awaited_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/polr_pkg.sv
hdl/polr_mul.sv
hdl/polr_div.sv
hdl/polygon_outline_rasterizer_unit.sv
hdl/polr_checker.sv
verif/polr_checker.sv
verif/tb_top.sv
